### rtl/core/locked_bank_mapper_unscrambler_core_macros.svh
// Assertion macros shared by the bank mapper core.
`ifndef LOCKED_BANK_MAPPER_UNSCRAMBLER_CORE_MACROS_SVH
`define LOCKED_BANK_MAPPER_UNSCRAMBLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge.
`define LBMU_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lbmu assertion failed");
// Next-cycle implication, checked on every rising clock edge.
`define LBMU_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lbmu assertion failed");
`else
`define LBMU_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define LBMU_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

### rtl/core/lbmu_pkg.sv
// Shared types, codes and constants of the bank mapper core.
`timescale 1ns / 1ps
package lbmu_pkg;

   // Bus access kinds.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // ROM region codes of a result.
   localparam logic [1:0] REGION_FIXED   = 2'd0;
   localparam logic [1:0] REGION_SWITCH  = 2'd1;
   localparam logic [1:0] REGION_OUTSIDE = 2'd2;
   localparam logic [1:0] REGION_WRITE   = 2'd3;

   // Lockout stages.
   localparam logic [1:0] LOCK_FIRST  = 2'd0;
   localparam logic [1:0] LOCK_SECOND = 2'd1;
   localparam logic [1:0] LOCK_OPEN   = 2'd2;

   // Write windows, selected by address bits 15:13.
   localparam logic [2:0] WIN_BASE    = 3'd0;
   localparam logic [2:0] WIN_BANK    = 3'd1;
   localparam logic [2:0] WIN_MASK    = 3'd2;
   localparam logic [2:0] WIN_TRIGGER = 3'd6;

   // Mapper constants.
   localparam logic [5:0]  UNLOCK_READS  = 6'h31;
   localparam logic [7:0]  CFG_OPEN_BITS = 8'h30;
   localparam logic [7:0]  PAGE_ONE      = 8'h01;
   localparam logic [15:0] LOCK_ADDR_BIT = 16'h0080;
   localparam logic [15:0] COUNT_MASK    = 16'h8700;
   localparam logic [15:0] COUNT_MATCH   = 16'h0100;
   localparam logic [15:0] KEEP_MASK     = 16'hFFAC;

   // Register port geometry and register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_VARIANT = 1'b0;

   typedef struct packed {
      logic        command;
      logic [15:0] address;
      logic [7:0]  write_data;
   } lbmu_request_type;

   typedef struct packed {
      logic [7:0]  fixed_bank;
      logic [7:0]  switch_bank;
      logic [1:0]  rom_region;
      logic [13:0] rom_offset;
      logic [1:0]  lock_stage;
   } lbmu_result_type;

endpackage

### rtl/core/lbmu_req_if.sv
// Request channel interface: one bus access per transfer.
`timescale 1ns / 1ps
interface lbmu_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output command, output address, output write_data,
                   input ready);
   modport sink (input valid, input command, input address, input write_data,
                 output ready);
endinterface

### rtl/core/lbmu_rsp_if.sv
// Result channel interface: mapped banks, region, offset and lock stage.
`timescale 1ns / 1ps
interface lbmu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  fixed_bank;
   logic [7:0]  switch_bank;
   logic [1:0]  rom_region;
   logic [13:0] rom_offset;
   logic [1:0]  lock_stage;

   modport source (output valid, output fixed_bank, output switch_bank,
                   output rom_region, output rom_offset, output lock_stage,
                   input ready);
   modport sink (input valid, input fixed_bank, input switch_bank,
                 input rom_region, input rom_offset, input lock_stage,
                 output ready);
endinterface

### rtl/core/lbmu_csr.sv
// Register port of the bank mapper core: holds the variant select.
`timescale 1ns / 1ps
module lbmu_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lbmu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lbmu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lbmu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic                            variant
);

   logic variant_ff;
   logic variant_in;
   logic write_hit;
   logic reg_index;

   // Registers sit on 32-bit word boundaries.
   assign reg_index = paddr[lbmu_pkg::CSR_ADDR_W-1];
   assign write_hit = psel && penable && pwrite && (reg_index == lbmu_pkg::REG_VARIANT);
   assign pready    = 1'b1;

   always_comb begin
      variant_in = variant_ff;
      if (write_hit) begin
         variant_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= 1'b0;
      end else begin
         variant_ff <= variant_in;
      end
   end

   // Read back the variant; unmapped addresses read as zero.
   always_comb begin
      prdata = '0;
      if (reg_index == lbmu_pkg::REG_VARIANT) begin
         prdata = {{(lbmu_pkg::CSR_DATA_W-1){1'b0}}, variant_ff};
      end
   end

   assign variant = variant_ff;

endmodule

### rtl/core/lbmu_mapper.sv
// Mapper state and the single-pass update for one bus access.
`timescale 1ns / 1ps
module lbmu_mapper (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       update,
   input  logic                       variant,
   input  lbmu_pkg::lbmu_request_type request,
   output lbmu_pkg::lbmu_result_type  result
);

   logic [7:0]  base_bank_ff, base_bank_in;
   logic [7:0]  bank_mask_ff, bank_mask_in;
   logic [7:0]  raw_bank_ff, raw_bank_in;
   logic [1:0]  lock_level_ff, lock_level_in;
   logic [5:0]  unlock_count_ff, unlock_count_in;
   logic [7:0]  low_bank_ff, low_bank_in;
   logic [7:0]  high_bank_ff, high_bank_in;

   logic        open_cfg;
   logic        page_one;
   logic        count_hit;
   logic [15:0] read_addr;
   logic [1:0]  region;
   logic [13:0] offset;

   // Swap the scrambled low address bits back into place.
   function automatic logic [15:0] unscramble(input logic [15:0] a);
      logic [15:0] r;
      r = a & lbmu_pkg::KEEP_MASK;
      r[0] = a[6];
      r[1] = a[4];
      r[4] = a[1];
      r[6] = a[0];
      return r;
   endfunction

   assign open_cfg  = (raw_bank_ff & lbmu_pkg::CFG_OPEN_BITS) == lbmu_pkg::CFG_OPEN_BITS;
   assign page_one  = request.address[15:8] == lbmu_pkg::PAGE_ONE;
   assign count_hit = (request.address & lbmu_pkg::COUNT_MASK) == lbmu_pkg::COUNT_MATCH;

   // Next state and translated read address for the access at hand.
   always_comb begin
      base_bank_in    = base_bank_ff;
      bank_mask_in    = bank_mask_ff;
      raw_bank_in     = raw_bank_ff;
      lock_level_in   = lock_level_ff;
      unlock_count_in = unlock_count_ff;
      low_bank_in     = low_bank_ff;
      high_bank_in    = high_bank_ff;
      read_addr       = request.address;

      if (request.command == lbmu_pkg::CMD_WRITE) begin
         case (request.address[15:13])
            lbmu_pkg::WIN_BASE: begin
               if (open_cfg) begin
                  base_bank_in = request.write_data;
                  low_bank_in  = request.write_data & bank_mask_ff;
               end
            end
            lbmu_pkg::WIN_BANK: begin
               raw_bank_in  = (request.write_data == 8'd0) ? 8'd1 : request.write_data;
               high_bank_in = (raw_bank_in & ~bank_mask_ff) | (base_bank_ff & bank_mask_ff);
            end
            lbmu_pkg::WIN_MASK: begin
               if (open_cfg) begin
                  bank_mask_in = request.write_data;
                  high_bank_in = (raw_bank_ff & ~request.write_data)
                               | (base_bank_ff & request.write_data);
                  low_bank_in  = base_bank_ff & request.write_data;
               end
            end
            lbmu_pkg::WIN_TRIGGER: begin
               if (variant && (lock_level_ff == lbmu_pkg::LOCK_FIRST)) begin
                  lock_level_in   = lbmu_pkg::LOCK_SECOND;
                  unlock_count_in = 6'd0;
               end
            end
            default: begin
            end
         endcase
      end else if (!variant) begin
         // First variant: one lock stage, counted by page-one reads.
         if ((lock_level_ff != lbmu_pkg::LOCK_OPEN) && page_one) begin
            unlock_count_in = 6'(unlock_count_ff + 6'd1);
            if (unlock_count_in == lbmu_pkg::UNLOCK_READS) begin
               lock_level_in = lbmu_pkg::LOCK_OPEN;
            end else begin
               read_addr = read_addr | lbmu_pkg::LOCK_ADDR_BIT;
            end
         end
         if (page_one) begin
            read_addr = unscramble(read_addr);
         end
      end else begin
         // Second variant: a high read moves the first stage to the second.
         if ((request.address[15:14] == 2'b11) && (lock_level_ff == lbmu_pkg::LOCK_FIRST)) begin
            unlock_count_in = 6'd0;
            lock_level_in   = lbmu_pkg::LOCK_SECOND;
         end
         if ((lock_level_in != lbmu_pkg::LOCK_OPEN) && count_hit) begin
            unlock_count_in = 6'(unlock_count_in + 6'd1);
            if (unlock_count_in == lbmu_pkg::UNLOCK_READS) begin
               lock_level_in   = 2'(lock_level_in + 2'd1);
               unlock_count_in = 6'd0;
            end
         end
         if (page_one) begin
            if (lock_level_in == lbmu_pkg::LOCK_SECOND) begin
               read_addr = read_addr | lbmu_pkg::LOCK_ADDR_BIT;
            end
            read_addr = unscramble(read_addr);
         end
      end
   end

   // Region and window offset of the access.
   always_comb begin
      offset = 14'd0;
      if (request.command == lbmu_pkg::CMD_WRITE) begin
         region = lbmu_pkg::REGION_WRITE;
      end else if (read_addr[15:14] == 2'b00) begin
         region = lbmu_pkg::REGION_FIXED;
         offset = read_addr[13:0];
      end else if (read_addr[15:14] == 2'b01) begin
         region = lbmu_pkg::REGION_SWITCH;
         offset = read_addr[13:0];
      end else begin
         region = lbmu_pkg::REGION_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_bank_ff    <= 8'd0;
         bank_mask_ff    <= 8'd0;
         raw_bank_ff     <= 8'd1;
         lock_level_ff   <= lbmu_pkg::LOCK_FIRST;
         unlock_count_ff <= 6'd0;
         low_bank_ff     <= 8'd0;
         high_bank_ff    <= 8'd1;
      end else if (update) begin
         base_bank_ff    <= base_bank_in;
         bank_mask_ff    <= bank_mask_in;
         raw_bank_ff     <= raw_bank_in;
         lock_level_ff   <= lock_level_in;
         unlock_count_ff <= unlock_count_in;
         low_bank_ff     <= low_bank_in;
         high_bank_ff    <= high_bank_in;
      end
   end

   // The result reports the state as it stands after this access.
   assign result.fixed_bank  = low_bank_in;
   assign result.switch_bank = high_bank_in;
   assign result.rom_region  = region;
   assign result.rom_offset  = offset;
   assign result.lock_stage  = lock_level_in;

endmodule

### rtl/core/locked_bank_mapper_unscrambler_core.sv
// Top level of the locked bank mapper: request register, mapper and result register.
//
// Usage: each request on req_ch is one CPU bus access (command, address,
// write_data). For every request one result leaves on rsp_ch with the
// fixed and switchable bank numbers, the ROM region and window offset of
// a read, and the lock stage after the access. Both channels transfer
// when valid and ready are high at a rising clock edge.
// The variant register (byte address 0 of the csr_ port) selects the
// mapper variant; write it only while no request is in flight.
// Flow: an accepted request is registered in the request register, passes
// the mapper logic and its result is captured in the result register.
// Throughput: one request per cycle while the receiver takes the results,
// set by the mapper update between the request register and the result register.
// Reset (synchronous, active high) empties both registers and returns the
// mapper to its locked first stage with bank 1 switched in.
// When the receiver stalls, the result register holds; one more request
// is still taken into the request register, then req_ch.ready drops.
`timescale 1ns / 1ps
`include "locked_bank_mapper_unscrambler_core_macros.svh"
module locked_bank_mapper_unscrambler_core (
   input  logic                            clock,
   input  logic                            reset,
   lbmu_req_if.sink                        req_ch,
   lbmu_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lbmu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lbmu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lbmu_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic                       variant;
   logic                       advance;
   logic                       req_fire;
   logic                       update;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   lbmu_pkg::lbmu_request_type s1_req_ff;
   lbmu_pkg::lbmu_result_type  rsp_data_ff;
   lbmu_pkg::lbmu_result_type  result;

   lbmu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .variant (variant)
   );

   lbmu_mapper u_mapper (
      .clock   (clock),
      .reset   (reset),
      .update  (update),
      .variant (variant),
      .request (s1_req_ff),
      .result  (result)
   );

   // Pipeline control: the result register frees up when empty or taken.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign update       = s1_valid_ff && advance;

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff.command    <= req_ch.command;
         s1_req_ff.address    <= req_ch.address;
         s1_req_ff.write_data <= req_ch.write_data;
      end
      if (update) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.fixed_bank  = rsp_data_ff.fixed_bank;
   assign rsp_ch.switch_bank = rsp_data_ff.switch_bank;
   assign rsp_ch.rom_region  = rsp_data_ff.rom_region;
   assign rsp_ch.rom_offset  = rsp_data_ff.rom_offset;
   assign rsp_ch.lock_stage  = rsp_data_ff.lock_stage;

   // Writes and reads outside ROM carry no offset.
   `LBMU_ASSERT_IMPLIES(a_write_offset, clock, reset, rsp_valid_ff && ((rsp_data_ff.rom_region == lbmu_pkg::REGION_WRITE) || (rsp_data_ff.rom_region == lbmu_pkg::REGION_OUTSIDE)), rsp_data_ff.rom_offset == 14'd0)
   // A request waiting behind a stalled result stays in the request register.
   `LBMU_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   // Reset leaves no result on the channel.
   `LBMU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid_ff && !s1_valid_ff)

endmodule

### verif/locked_bank_mapper_unscrambler_core_test.sv
// Self-checking testbench of the locked bank mapper core with a built-in access predictor.
`timescale 1ns / 1ps
module locked_bank_mapper_unscrambler_core_test;
   import lbmu_pkg::*;

   // Values of the variant register.
   localparam logic VARIANT_ONE_STAGE = 1'b0;
   localparam logic VARIANT_TWO_STAGE = 1'b1;

   // Ways the two-stage lockout leaves its first stage in a run.
   localparam int LEAVE_BY_COUNT = 0;
   localparam int LEAVE_BY_READ  = 1;
   localparam int LEAVE_BY_WRITE = 2;

   localparam logic [15:0] TRIGGER_FLOOR  = 16'hC000;
   localparam int          TARGET_ACCESSES = 950;
   localparam int          QUIET_ACCESSES  = 120;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int          WATCHDOG_LIMIT  = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lbmu_req_if req_ch ();
   lbmu_rsp_if rsp_ch ();

   locked_bank_mapper_unscrambler_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Predicted mapper state, starting from its reset values.
   logic       map_variant = VARIANT_ONE_STAGE;
   logic [7:0] map_base    = 8'h00;
   logic [7:0] map_mask    = 8'h00;
   logic [7:0] map_raw     = 8'h01;
   logic [1:0] map_lock    = LOCK_FIRST;
   logic [5:0] map_count   = 6'd0;
   logic [7:0] map_low     = 8'h00;
   logic [7:0] map_high    = 8'h01;

   lbmu_result_type expected_results[$];
   int              access_count = 0;
   int              error_count  = 0;
   int              idle_cycles  = 0;
   int              stall_left   = 0;
   bit              gaps_on      = 1'b0;
   bit              stalls_on    = 1'b0;

   // Undo the scrambling of the low address bits of a page-one read.
   function automatic logic [15:0] unscramble_addr(input logic [15:0] a);
      logic [15:0] r;
      r    = a & KEEP_MASK;
      r[0] = a[6];
      r[1] = a[4];
      r[4] = a[1];
      r[6] = a[0];
      return r;
   endfunction

   function automatic logic [7:0] merged_switch();
      return (map_raw & ~map_mask) | (map_base & map_mask);
   endfunction

   // Apply one bus access to the predicted state and return its result.
   function automatic lbmu_result_type map_access(input lbmu_request_type acc);
      lbmu_result_type res;
      logic [15:0]     a;
      logic            page_one;
      logic            cfg_open;
      a          = acc.address;
      page_one   = (a[15:8] == PAGE_ONE);
      cfg_open   = ((map_raw & CFG_OPEN_BITS) == CFG_OPEN_BITS);
      res.rom_region = REGION_WRITE;
      res.rom_offset = '0;
      if (acc.command == CMD_WRITE) begin
         case (a[15:13])
            WIN_BASE: begin
               if (cfg_open) begin
                  map_base = acc.write_data;
                  map_low  = map_base & map_mask;
               end
            end
            WIN_BANK: begin
               map_raw  = (acc.write_data == 8'h00) ? 8'h01 : acc.write_data;
               map_high = merged_switch();
            end
            WIN_MASK: begin
               if (cfg_open) begin
                  map_mask = acc.write_data;
                  map_high = merged_switch();
                  map_low  = map_base & map_mask;
               end
            end
            WIN_TRIGGER: begin
               if (map_variant == VARIANT_TWO_STAGE && map_lock == LOCK_FIRST) begin
                  map_lock  = LOCK_SECOND;
                  map_count = '0;
               end
            end
            default: ;
         endcase
      end else begin
         if (map_variant == VARIANT_ONE_STAGE) begin
            // One stage: every page-one read counts while locked.
            if (map_lock != LOCK_OPEN && page_one) begin
               map_count = map_count + 6'd1;
               if (map_count == UNLOCK_READS)
                  map_lock = LOCK_OPEN;
               else
                  a = a | LOCK_ADDR_BIT;
            end
         end else begin
            // Two stages: a high read ends the first stage, masked reads count.
            if (a >= TRIGGER_FLOOR && map_lock == LOCK_FIRST) begin
               map_count = '0;
               map_lock  = LOCK_SECOND;
            end
            if (map_lock != LOCK_OPEN && (a & COUNT_MASK) == COUNT_MATCH) begin
               map_count = map_count + 6'd1;
               if (map_count == UNLOCK_READS) begin
                  map_lock  = map_lock + 2'd1;
                  map_count = '0;
               end
            end
            if (page_one && map_lock == LOCK_SECOND)
               a = a | LOCK_ADDR_BIT;
         end
         if (page_one)
            a = unscramble_addr(a);
         case (a[15:14])
            2'b00: begin
               res.rom_region = REGION_FIXED;
               res.rom_offset = a[13:0];
            end
            2'b01: begin
               res.rom_region = REGION_SWITCH;
               res.rom_offset = a[13:0];
            end
            default: res.rom_region = REGION_OUTSIDE;
         endcase
      end
      res.fixed_bank  = map_low;
      res.switch_bank = map_high;
      res.lock_stage  = map_lock;
      return res;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Result side: random stalls, and each result checked against the oldest prediction.
   always @(posedge clock) begin : check_results
      lbmu_result_type want;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h %h %0d %h %0d",
                     $time, rsp_ch.fixed_bank, rsp_ch.switch_bank, rsp_ch.rom_region,
                     rsp_ch.rom_offset, rsp_ch.lock_stage);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("fixed_bank", want.fixed_bank, rsp_ch.fixed_bank);
            check_field("switch_bank", want.switch_bank, rsp_ch.switch_bank);
            check_field("rom_region", want.rom_region, rsp_ch.rom_region);
            check_field("rom_offset", want.rom_offset, rsp_ch.rom_offset);
            check_field("lock_stage", want.lock_stage, rsp_ch.lock_stage);
         end
      end
      if (stall_left > 0)
         stall_left--;
      else if (stalls_on && $urandom_range(0, 3) == 0)
         stall_left = $urandom_range(1, 5);
      rsp_ch.ready <= (stall_left == 0);
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, expected_results.size());
         $display("locked_bank_mapper_unscrambler_core_test: FAIL");
         $finish;
      end
   end

   // Send one request, with an optional gap in front, and predict its result.
   task automatic send_access(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
      lbmu_request_type acc;
      acc.command    = cmd;
      acc.address    = addr;
      acc.write_data = data;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.address    <= addr;
      req_ch.write_data <= data;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_results.push_back(map_access(acc));
      access_count++;
   endtask

   // Drain the mapper, then write the variant register and read it back.
   task automatic set_variant(input logic v);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_VARIANT, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      map_variant = v;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_W'(v)) begin
         $display("%0t: variant readback mismatch: expected %0h, actual %0h",
                  $time, CSR_DATA_W'(v), csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [15:0] counted_addr();
      return {1'b0, 4'($urandom), COUNT_MATCH[10:8], 8'($urandom)};
   endfunction

   function automatic logic [7:0] bank_data();
      return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
   endfunction

   task automatic send_noise(input int top_addr);
      send_access(1'($urandom), 16'($urandom_range(0, top_addr)), bank_data());
   endtask

   // Mix of page-one reads, counted reads, window writes and plain accesses.
   task automatic send_mixed();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         send_access(CMD_READ, {PAGE_ONE, 8'($urandom)}, 8'($urandom));
      else if (pick < 25)
         send_access(CMD_READ, counted_addr(), 8'($urandom));
      else if (pick < 40)
         send_access(CMD_WRITE, {3'($urandom_range(WIN_BASE, WIN_MASK)), 13'($urandom)},
                     bank_data());
      else
         send_noise(16'hFFFF);
   endtask

   // Reads across every region straight after reset.
   task automatic test_reset_state();
      set_variant(VARIANT_ONE_STAGE);
      send_access(CMD_READ, 16'h0000, 8'h00);
      send_access(CMD_READ, 16'h3FFF, 8'hFF);
      send_access(CMD_READ, 16'h4000, 8'h00);
      send_access(CMD_READ, 16'h7FFF, 8'hFF);
      send_access(CMD_READ, 16'h8000, 8'h00);
      send_access(CMD_READ, 16'hFFFF, 8'hFF);
   endtask

   // Gated base and mask writes, bank zero, and writes that are ignored.
   task automatic test_write_windows();
      send_access(CMD_WRITE, 16'h1FFF, 8'hAA);
      send_access(CMD_WRITE, 16'h4000, 8'hFF);
      send_access(CMD_WRITE, 16'h2000, 8'h00);
      send_access(CMD_WRITE, 16'h3FFF, 8'hFF);
      send_access(CMD_WRITE, 16'h0000, 8'hFF);
      send_access(CMD_WRITE, 16'h5FFF, 8'h0F);
      send_access(CMD_WRITE, 16'h1000, 8'hA5);
      send_access(CMD_WRITE, 16'h6000, 8'h55);
      send_access(CMD_WRITE, 16'hBFFF, 8'h55);
      send_access(CMD_WRITE, 16'hC000, 8'h55);
      send_access(CMD_WRITE, 16'hFFFF, 8'hFF);
      send_access(CMD_READ, 16'h7ABC, 8'h00);
   endtask

   // Locked page-one reads with unscrambled low address bits.
   task automatic test_page_one_reads();
      send_access(CMD_READ, 16'h0100, 8'h00);
      send_access(CMD_READ, 16'h01FF, 8'h00);
      send_access(CMD_READ, 16'h0155, 8'h00);
      send_access(CMD_READ, 16'h01AA, 8'h00);
   endtask

   // Walk the two-stage lockout, then finish unlocking in either variant.
   task automatic test_two_stage_lockout();
      int leave_kind;
      int pick;
      set_variant(VARIANT_TWO_STAGE);
      gaps_on    = 1'b1;
      stalls_on  = 1'b1;
      leave_kind = $urandom_range(LEAVE_BY_COUNT, LEAVE_BY_WRITE);
      while (map_lock == LOCK_FIRST) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_access(CMD_READ, counted_addr(), 8'($urandom));
         else if (pick < 58 && leave_kind == LEAVE_BY_READ)
            send_access(CMD_READ, 16'($urandom_range(TRIGGER_FLOOR, 16'hFFFF)), 8'($urandom));
         else if (pick < 58 && leave_kind == LEAVE_BY_WRITE)
            send_access(CMD_WRITE, {WIN_TRIGGER, 13'($urandom)}, 8'($urandom));
         else
            send_noise(16'hBFFF);
      end
      // Second stage in the two-stage variant for a random stretch.
      repeat ($urandom_range(10, 150)) begin
         if ($urandom_range(0, 99) < 40)
            send_access(CMD_READ, counted_addr(), 8'($urandom));
         else
            send_noise(16'hFFFF);
      end
      // Switch variant while still locked; the count carries over.
      if (map_lock != LOCK_OPEN) begin
         set_variant(VARIANT_ONE_STAGE);
         while (map_lock != LOCK_OPEN) begin
            if ($urandom_range(0, 99) < 40)
               send_access(CMD_READ, {PAGE_ONE, 8'($urandom)}, 8'($urandom));
            else
               send_noise(16'hFFFF);
         end
      end
   endtask

   // Unlocked traffic over several variant settings; the last stretch runs without idling.
   task automatic test_open_mix();
      while (access_count < TARGET_ACCESSES - QUIET_ACCESSES) begin
         set_variant(1'($urandom));
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(60, 180)) send_mixed();
      end
      set_variant(1'($urandom));
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (QUIET_ACCESSES) send_mixed();
   endtask

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_READ;
      req_ch.address    <= '0;
      req_ch.write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_write_windows();
      test_page_one_reads();
      test_two_stage_lockout();
      test_open_mix();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("locked_bank_mapper_unscrambler_core_test: PASS");
      else
         $display("locked_bank_mapper_unscrambler_core_test: FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lbmu_pkg.sv
rtl/core/lbmu_req_if.sv
rtl/core/lbmu_rsp_if.sv
rtl/core/lbmu_csr.sv
rtl/core/lbmu_mapper.sv
rtl/core/locked_bank_mapper_unscrambler_core.sv
verif/locked_bank_mapper_unscrambler_core_test.sv
